@@ hw/rtl/lmspe_pkg.sv @@
`timescale 1ns / 1ps

package lmspe_pkg;

   localparam int FRONT_ROWS     = 8;
   localparam int FRONT_COLS_DEF = 7;
   localparam int REAR_COLS_DEF  = 22;
   localparam int REAR_ROWS      = 4;
   localparam int DIRECT_BASE    = 16;
   localparam int DIRECT_PINS    = 6;
   localparam int ROW_W          = $clog2(FRONT_ROWS);

   typedef enum logic [1:0] {
      KIND_SCAN    = 2'd0,
      KIND_PATTERN = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_GLYPH   = 2'd3
   } kind_type;

   localparam logic [1:0] TARGET_FRONT_UPPER = 2'd0;
   localparam logic [1:0] TARGET_FRONT_LOWER = 2'd1;
   localparam logic [1:0] TARGET_REAR        = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  target;
      logic [2:0]  slot;
      logic [7:0]  character;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  front_row_drive;
      logic [6:0]  front_columns;
      logic [4:0]  rear_column;
      logic [3:0]  rear_rows;
      logic [3:0]  demux_select;
      logic        demux_enable;
      logic [5:0]  direct_columns;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0] pos;
      logic       down;
   } chaser_type;

   // 3-bit wide digits, one entry per front row of the glyph
   localparam logic [2:0] FONT_FRONT_DIGIT [10][4] = '{
      '{3'd7, 3'd5, 3'd5, 3'd7}, '{3'd4, 3'd4, 3'd4, 3'd4}, '{3'd7, 3'd4, 3'd1, 3'd7},
      '{3'd7, 3'd4, 3'd4, 3'd7}, '{3'd5, 3'd7, 3'd4, 3'd4}, '{3'd7, 3'd1, 3'd4, 3'd7},
      '{3'd7, 3'd1, 3'd7, 3'd7}, '{3'd7, 3'd4, 3'd4, 3'd4}, '{3'd7, 3'd7, 3'd7, 3'd7},
      '{3'd7, 3'd7, 3'd4, 3'd7}
   };

   // rear glyphs are three columns of four row bits
   localparam logic [3:0] FONT_REAR_DIGIT [10][3] = '{
      '{4'hF, 4'h9, 4'hF}, '{4'h0, 4'h0, 4'hF}, '{4'hD, 4'h9, 4'hB}, '{4'h9, 4'h9, 4'hF},
      '{4'h3, 4'h2, 4'hF}, '{4'hB, 4'h9, 4'hD}, '{4'hF, 4'hD, 4'hD}, '{4'h1, 4'h1, 4'hF},
      '{4'hF, 4'hF, 4'hF}, '{4'hB, 4'hB, 4'hF}
   };

   localparam logic [3:0] FONT_REAR_LETTER [26][3] = '{
      '{4'hF, 4'h3, 4'hF}, '{4'hF, 4'hA, 4'hE}, '{4'hF, 4'h9, 4'h9}, '{4'hF, 4'h9, 4'h6},
      '{4'hF, 4'hD, 4'h9}, '{4'hF, 4'h3, 4'h1}, '{4'hF, 4'h9, 4'hD}, '{4'hF, 4'h2, 4'hF},
      '{4'h0, 4'hF, 4'h0}, '{4'hC, 4'h8, 4'hF}, '{4'hF, 4'h4, 4'hA}, '{4'hF, 4'h8, 4'h8},
      '{4'hD, 4'h2, 4'hD}, '{4'hC, 4'h2, 4'hC}, '{4'hE, 4'hA, 4'hE}, '{4'hF, 4'h3, 4'h3},
      '{4'hF, 4'hD, 4'hF}, '{4'hF, 4'h5, 4'hB}, '{4'hB, 4'h9, 4'hD}, '{4'h1, 4'hF, 4'h1},
      '{4'hF, 4'h8, 4'hF}, '{4'h7, 4'h8, 4'h7}, '{4'hB, 4'h4, 4'hB}, '{4'h9, 4'h6, 4'h9},
      '{4'h3, 4'hC, 4'h3}, '{4'hD, 4'h9, 4'hB}
   };

   // bounce between 0 and last: turn at the ends, then step one position
   function automatic chaser_type step_chaser(input chaser_type cur, input logic [4:0] last);
      chaser_type nxt;
      nxt = cur;
      if (cur.pos >= last) nxt.down = 1'b1;
      if (cur.pos == 5'd0) nxt.down = 1'b0;
      if (nxt.down) begin
         if (cur.pos != 5'd0) nxt.pos = cur.pos - 5'd1;
      end else if (cur.pos < last) begin
         nxt.pos = cur.pos + 5'd1;
      end
      return nxt;
   endfunction

endpackage

@@ hw/rtl/led_matrix_scan_and_pattern_engine_top.sv @@
`timescale 1ns / 1ps

// LED matrix scan and pattern engine.
//
// req_* carries one beat per event: scan tick, pattern tick, clear, or glyph
// placement. Only a scan tick produces a beat on rsp_*, holding the front row
// one-hot with its column bits and the rear column with its row bits and
// column drive (demux for columns below 16, active-low direct pins above).
// csr_* writes display_mode (0 character, 1 chaser); csr_ready is always high.
//
// Each event updates the frames and counters at the edge the beat is accepted,
// and the scan result appears in the rsp register on the next cycle. One beat
// can be accepted every cycle while req_stall is low.
// The rsp register is the only buffer: while it holds a beat and rsp_stall is
// high, req_stall is raised; otherwise input is taken regardless of rsp_stall.
//
// Synchronous reset clears both frames, the scan counters, the chasers and
// display_mode, and empties the rsp register. The first scan after reset
// shows front row 1 and rear column 1.

module led_matrix_scan_and_pattern_engine_top
   import lmspe_pkg::*;
#(
   parameter int FRONT_COLS = FRONT_COLS_DEF,
   parameter int REAR_COLS  = REAR_COLS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   localparam int COL_W       = $clog2(REAR_COLS);
   localparam int FPOS_W      = $clog2(FRONT_COLS);
   localparam int FRONT_SLOTS = (FRONT_COLS + 1) / 4;
   localparam int REAR_SLOTS  = (REAR_COLS + 1) / 4;

   logic [FRONT_COLS-1:0] front_ff [FRONT_ROWS];
   logic [FRONT_COLS-1:0] front_in [FRONT_ROWS];
   logic [REAR_ROWS-1:0]  rear_ff  [REAR_COLS];
   logic [REAR_ROWS-1:0]  rear_in  [REAR_COLS];

   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [FPOS_W-1:0] front_pos_ff, front_pos_in;
   logic              front_down_ff, front_down_in;
   logic [COL_W-1:0]  rear_pos_ff, rear_pos_in;
   logic              rear_down_ff, rear_down_in;
   logic              half_ff, half_in;
   logic              mode_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic scan_accept;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_accept  = req_valid & ~req_stall;
   assign scan_accept = req_accept & (req_payload.kind == KIND_SCAN);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready   = 1'b1;

   // glyph decode
   logic                  is_digit, is_letter;
   logic [3:0]            digit_idx;
   logic [4:0]            letter_idx;
   logic                  front_ok, rear_ok;
   logic [2:0]            front_off;
   logic [FRONT_COLS-1:0] front_line [4];
   logic [3:0]            rear_glyph [3];
   logic [7:0]            digit_diff, letter_diff;

   always_comb begin
      digit_diff  = req_payload.character - 8'h30;
      letter_diff = req_payload.character - 8'h41;
      is_digit    = (req_payload.character >= 8'h30) && (req_payload.character <= 8'h39);
      is_letter   = (req_payload.character >= 8'h41) && (req_payload.character <= 8'h5A);
      digit_idx   = is_digit ? digit_diff[3:0] : 4'd0;
      letter_idx  = is_letter ? letter_diff[4:0] : 5'd0;
      front_ok    = is_digit && (int'(req_payload.slot) < FRONT_SLOTS) &&
                    ((req_payload.target == TARGET_FRONT_UPPER) ||
                     (req_payload.target == TARGET_FRONT_LOWER));
      rear_ok     = (is_digit || is_letter) && (int'(req_payload.slot) < REAR_SLOTS) &&
                    (req_payload.target == TARGET_REAR);
      front_off   = front_ok ? 3'(((FRONT_SLOTS - 1) - int'(req_payload.slot)) * 4) : 3'd0;
      for (int i = 0; i < 4; i++) begin
         front_line[i] = FRONT_COLS'({5'd0, FONT_FRONT_DIGIT[digit_idx][i]} << front_off);
      end
      for (int i = 0; i < 3; i++) begin
         rear_glyph[i] = is_digit ? FONT_REAR_DIGIT[digit_idx][i] :
                                    FONT_REAR_LETTER[letter_idx][i];
      end
   end

   // next state of frames and counters
   chaser_type front_step, rear_step;
   logic [FRONT_COLS-1:0] chase_bits;

   always_comb begin
      front_in      = front_ff;
      rear_in       = rear_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      front_pos_in  = front_pos_ff;
      front_down_in = front_down_ff;
      rear_pos_in   = rear_pos_ff;
      rear_down_in  = rear_down_ff;
      half_in       = half_ff;

      front_step = step_chaser('{pos: 5'(front_pos_ff), down: front_down_ff},
                               5'(FRONT_COLS - 1));
      rear_step  = step_chaser('{pos: 5'(rear_pos_ff), down: rear_down_ff},
                               5'(REAR_COLS - 1));
      chase_bits = '0;
      chase_bits[front_pos_ff] = 1'b1;

      if (req_accept) begin
         case (req_payload.kind)
            KIND_SCAN: begin
               scan_row_in = scan_row_ff + ROW_W'(1);
               scan_col_in = (scan_col_ff == COL_W'(REAR_COLS - 1)) ? '0 :
                             scan_col_ff + COL_W'(1);
            end
            KIND_PATTERN: begin
               if (mode_ff) begin
                  for (int r = 0; r < FRONT_ROWS; r++) front_in[r] = chase_bits;
                  for (int c = 0; c < REAR_COLS; c++) begin
                     rear_in[c] = (COL_W'(c) == rear_pos_ff) ? '1 : '0;
                  end
                  if (half_ff) begin
                     front_pos_in  = FPOS_W'(front_step.pos);
                     front_down_in = front_step.down;
                  end
                  half_in      = ~half_ff;
                  rear_pos_in  = COL_W'(rear_step.pos);
                  rear_down_in = rear_step.down;
               end
            end
            KIND_CLEAR: begin
               for (int r = 0; r < FRONT_ROWS; r++) front_in[r] = '0;
               for (int c = 0; c < REAR_COLS; c++) rear_in[c] = '0;
            end
            default: begin
               // rows 0-3 are the upper area, 4-7 the lower
               for (int r = 0; r < FRONT_ROWS; r++) begin
                  if (front_ok && (int'(req_payload.target) == (r >> 2))) begin
                     front_in[r] = front_ff[r] | front_line[r & 3];
                  end
               end
               // slot s owns columns 4s..4s+2; the fourth column is a gap
               for (int c = 0; c < REAR_COLS; c++) begin
                  if (rear_ok && (int'(req_payload.slot) == (c >> 2)) && ((c & 3) != 3)) begin
                     rear_in[c] = rear_ff[c] | rear_glyph[c & 3];
                  end
               end
            end
         endcase
      end
   end

   // scan result
   logic [4:0] direct_bit;

   always_comb begin
      direct_bit = 5'(scan_col_in) - 5'(DIRECT_BASE);
      rsp_data_in.front_row_drive = 8'(1 << scan_row_in);
      rsp_data_in.front_columns   = 7'(front_ff[scan_row_in]);
      rsp_data_in.rear_column     = 5'(scan_col_in);
      rsp_data_in.rear_rows       = rear_ff[scan_col_in];
      if (int'(scan_col_in) < DIRECT_BASE) begin
         rsp_data_in.demux_select   = 4'(scan_col_in);
         rsp_data_in.demux_enable   = 1'b1;
         rsp_data_in.direct_columns = '1;
      end else begin
         rsp_data_in.demux_select   = 4'd0;
         rsp_data_in.demux_enable   = 1'b0;
         rsp_data_in.direct_columns = (int'(direct_bit) < DIRECT_PINS) ?
                                      ~6'(1 << direct_bit) : '1;
      end
      rsp_valid_in = scan_accept ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < FRONT_ROWS; r++) front_ff[r] <= '0;
         for (int c = 0; c < REAR_COLS; c++) rear_ff[c] <= '0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         front_pos_ff  <= '0;
         front_down_ff <= 1'b0;
         rear_pos_ff   <= '0;
         rear_down_ff  <= 1'b0;
         half_ff       <= 1'b0;
         mode_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         front_pos_ff  <= front_pos_in;
         front_down_ff <= front_down_in;
         rear_pos_ff   <= rear_pos_in;
         rear_down_ff  <= rear_down_in;
         half_ff       <= half_in;
         if (csr_valid) mode_ff <= csr_data;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_accept) rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_scan_gives_beat: assert property (@(posedge clock) disable iff (reset)
      scan_accept |=> rsp_valid_ff)
      else $error("scan beat did not produce a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !scan_accept)
      else $error("stalled response overwritten");

   a_positions_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(scan_col_ff) < REAR_COLS) && (int'(rear_pos_ff) < REAR_COLS) &&
      (int'(front_pos_ff) < FRONT_COLS))
      else $error("scan or chaser position out of range");

   a_single_column_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.demux_enable && rsp_data_ff.direct_columns == 6'h3F) ||
                        (!rsp_data_ff.demux_enable &&
                         $countones(~rsp_data_ff.direct_columns) == 1)))
      else $error("more than one rear column driven");

   a_pattern_ignored: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.kind == KIND_PATTERN && !mode_ff) |=>
      $stable(rear_pos_ff) && $stable(half_ff))
      else $error("pattern tick changed state in character mode");

endmodule
